[rtl/mtc_pkg.sv]
// Shared types, constants and fixed-point helpers for the multipole to
// triplet correlation block. No dependencies.
package mtc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_LANES     = 5;
    localparam int NUM_COMP      = 4;

    localparam logic [63:0] PHASOR_ONE    = 64'h4000_0000_0000_0000;
    localparam logic [15:0] INV_PHI_RESET = 16'd2048;
    localparam logic [30:0] THRESH_RESET  = 31'd6554;

    // register select, taken from paddr[2]
    localparam logic REG_INV_PHI = 1'b0;
    localparam logic REG_THRESH  = 1'b1;

    localparam logic signed [39:0] MAX32 = 40'sd2147483647;
    localparam logic signed [39:0] MIN32 = -40'sd2147483648;

    typedef struct packed {
        logic mul_en;
        logic conj;
        logic acc_en;
        logic scale_en;
        logic clear;
    } lane_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ACC1,
        S_ACC2,
        S_SCALE,
        S_SQ,
        S_ROOT,
        S_ROOTW,
        S_DIV0,
        S_DIVW0,
        S_DIV1,
        S_DIVW1,
        S_DONE
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > MAX32) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < MIN32) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // round a Q2.30-scaled product sum back to the data scale, halves up
    function automatic logic signed [35:0] rnd30(input logic signed [64:0] s);
        logic signed [65:0] t;
        t = {s[64], s} + 66'sd536870912;
        return t[65:30];
    endfunction

endpackage

[rtl/mtc_lane.sv]
// One complex multiply-accumulate lane with saturation and bin scaling.
// Depends on mtc_pkg.
module mtc_lane (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mtc_pkg::lane_ctl_t    ctl,
    input  logic [63:0]           x_op,
    input  logic [63:0]           w_op,
    input  logic [15:0]           inv_phi,
    output logic signed [31:0]    sc_re,
    output logic signed [31:0]    sc_im
);

    logic signed [31:0] xr, xi, wr, wi;
    logic signed [63:0] prr_reg, pii_reg, pri_reg, pir_reg;
    logic               conj_reg;
    logic signed [31:0] acc_re_reg, acc_im_reg, acc_re_next, acc_im_next;
    logic signed [31:0] sc_re_reg, sc_im_reg;
    logic signed [64:0] re_sum, im_sum;
    logic signed [35:0] re_t, im_t;
    logic signed [48:0] sp_re, sp_im;
    logic signed [48:0] sr_re, sr_im;

    assign xr = x_op[63:32];
    assign xi = x_op[31:0];
    assign wr = w_op[63:32];
    assign wi = w_op[31:0];

    always_comb begin
        if (conj_reg) begin
            re_sum = {prr_reg[63], prr_reg} + {pii_reg[63], pii_reg};
            im_sum = {pir_reg[63], pir_reg} - {pri_reg[63], pri_reg};
        end else begin
            re_sum = {prr_reg[63], prr_reg} - {pii_reg[63], pii_reg};
            im_sum = {pri_reg[63], pri_reg} + {pir_reg[63], pir_reg};
        end
        re_t = mtc_pkg::rnd30(re_sum);
        im_t = mtc_pkg::rnd30(im_sum);
        acc_re_next = mtc_pkg::sat32({{8{acc_re_reg[31]}}, acc_re_reg}
                                     + {{4{re_t[35]}}, re_t});
        acc_im_next = mtc_pkg::sat32({{8{acc_im_reg[31]}}, acc_im_reg}
                                     + {{4{im_t[35]}}, im_t});
        sp_re = acc_re_reg * $signed({1'b0, inv_phi});
        sp_im = acc_im_reg * $signed({1'b0, inv_phi});
        sr_re = sp_re + 49'sd32768;
        sr_im = sp_im + 49'sd32768;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if (ctl.acc_en) begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prr_reg  <= xr * wr;
            pii_reg  <= xi * wi;
            pri_reg  <= xr * wi;
            pir_reg  <= xi * wr;
            conj_reg <= ctl.conj;
        end
        if (ctl.scale_en) begin
            sc_re_reg <= mtc_pkg::sat32({{7{sr_re[48]}}, sr_re[48:16]});
            sc_im_reg <= mtc_pkg::sat32({{7{sr_im[48]}}, sr_im[48:16]});
        end
    end

    assign sc_re = sc_re_reg;
    assign sc_im = sc_im_reg;

endmodule

[rtl/mtc_isqrt.sv]
// Iterative integer square root, two radicand bits per cycle.
// No package dependencies.
module mtc_isqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] val,
    output logic        busy,
    output logic [31:0] root
);

    logic [63:0] rad_reg;
    logic [34:0] rem_reg;
    logic [31:0] root_reg;
    logic [5:0]  cnt_reg;
    logic [34:0] rem_sh, trial;
    logic        ge;

    assign rem_sh = {rem_reg[32:0], rad_reg[63:62]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= 6'd32;
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= val;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cnt_reg != '0) begin
            rad_reg  <= {rad_reg[61:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[30:0], ge};
        end
    end

    assign busy = cnt_reg != '0;
    assign root = root_reg;

endmodule

[rtl/mtc_div.sv]
// Restoring divider, one quotient bit per cycle, 32-bit divisor.
// No package dependencies.
module mtc_div #(
    parameter int NW = 49
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [31:0]   den,
    output logic          busy,
    output logic [NW-1:0] quot
);

    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg;
    logic [31:0]   rem_reg;
    logic [NW-1:0] qn_reg;
    logic [32:0]   rem_sh, diff;
    logic          ge;

    assign rem_sh = {rem_reg, qn_reg[NW-1]};
    assign diff   = rem_sh - {1'b0, den};
    assign ge     = rem_sh >= {1'b0, den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CW'(NW);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            qn_reg  <= num;
        end else if (cnt_reg != '0) begin
            rem_reg <= ge ? diff[31:0] : rem_sh[31:0];
            qn_reg  <= {qn_reg[NW-2:0], ge};
        end
    end

    assign busy = cnt_reg != '0;
    assign quot = qn_reg;

endmodule

[rtl/multipole_to_triplet_correlation.sv]
// Top level of the multipole to triplet correlation block: sequencer, lanes,
// root and divider units, output register and APB registers.
// Depends on mtc_pkg, mtc_lane, mtc_isqrt and mtc_div.
//
// Usage: the s_ channel carries one multipole order per beat; s_tlast marks
// the highest order of a bin. Five lanes (normalization, four components)
// each run a complex multiply-accumulate against the running phasor power.
// One beat per bin comes out on the m_ channel, after the beat with s_tlast.
// Input: each beat is accepted in the idle state, then plus products, plus
// accumulate with minus products and minus accumulate follow before the
// next beat is taken; the lane multipliers are shared between the plus
// and minus terms. Bin close runs scale, square, root, a real and then an
// imaginary divide pass (divider width NW = 33 + FRAC_BITS) and output;
// the divide part is skipped when the normalization is low.
// The root and the four per-lane dividers are bit-serial units.
// Reset: synchronous, active low; clears the phasor to one, the accumulators
// to zero and the output valid; sets the first-order flag and the registers to
// their defaults (inv_phi_bins 2048, count_threshold 6554).
// Stall: a finished result waits in the output register; the block keeps
// accepting beats, and only holds at bin close until that register frees.
module multipole_to_triplet_correlation #(
    parameter int FRAC_BITS = mtc_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata, from bit 0 up: phase, count_plus, count_minus, plus_c0..plus_c3,
    // minus_c0..minus_c3 (64 bits each)
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [703:0] s_tdata,
    input  logic         s_tlast,     // is_last
    // m_tdata, from bit 0 up: norm_out, gamma0, gamma1, gamma2, gamma3
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [319:0] m_tdata,
    output logic [0:0]   m_tuser,     // low_count
    // register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int NW = 33 + FRAC_BITS;
    localparam int NL = mtc_pkg::NUM_LANES;
    localparam int NC = mtc_pkg::NUM_COMP;

    mtc_pkg::state_t    state_reg, state_next;
    mtc_pkg::lane_ctl_t lane_ctl;

    logic [15:0]  inv_phi_reg;
    logic [30:0]  thresh_reg;
    logic [703:0] item_reg;
    logic         last_reg;
    logic         first_reg, first_next;
    logic [63:0]  w_reg, w_next;
    logic signed [63:0] pw_rr_reg, pw_ii_reg, pw_ri_reg, pw_ir_reg;
    logic signed [31:0] wr, wi, pr, pi;

    logic [63:0]        x_op [NL];
    logic signed [31:0] sc_re [NL];
    logic signed [31:0] sc_im [NL];

    logic signed [63:0] sq_re_reg, sq_im_reg;
    logic [61:0]        tt_reg;
    logic [63:0]        sum_sq;
    logic               low_reg;
    logic               sqrt_start, sqrt_busy;
    logic [31:0]        root;

    logic               div_start;
    logic [NW-1:0]      div_num [NC];
    logic [NW-1:0]      div_quot [NC];
    logic [NC-1:0]      div_busy;
    logic [31:0]        gam_re_reg [NC];
    logic [31:0]        gam_im_reg [NC];

    logic               out_free;
    logic               m_tvalid_reg;
    logic [319:0]       m_tdata_reg;
    logic               m_tuser_reg;
    logic               cfg_wr;

    // numerator |v| * 2^FRAC_BITS + m/2
    function automatic logic [NW-1:0] mk_num(input logic signed [31:0] v,
                                             input logic [31:0] m);
        logic [31:0] a;
        a = v[31] ? 32'(-v) : 32'(v);
        return {1'b0, a, {FRAC_BITS{1'b0}}} + NW'(m[31:1]);
    endfunction

    // clamp quotient, apply sign, saturate
    function automatic logic [31:0] fix_q(input logic [NW-1:0] q, input logic neg);
        logic [31:0] qc;
        qc = (|q[NW-1:31]) ? 32'h8000_0000 : q[31:0];
        if (neg) begin
            return 32'(-qc);
        end
        return qc[31] ? 32'h7FFF_FFFF : qc;
    endfunction

    // ---------------------------------------------------------------- config
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == mtc_pkg::REG_THRESH) ? {1'b0, thresh_reg}
                                                      : {16'd0, inv_phi_reg};

    // ---------------------------------------------------------------- lanes
    // plus operands feed the products, minus operands (with components 2 and
    // 3 swapped) feed the conjugate products in the cycle after
    always_comb begin
        if (state_reg == mtc_pkg::S_ACC1) begin
            x_op[0] = item_reg[191:128];
            x_op[1] = item_reg[511:448];
            x_op[2] = item_reg[575:512];
            x_op[3] = item_reg[703:640];
            x_op[4] = item_reg[639:576];
        end else begin
            x_op[0] = item_reg[127:64];
            x_op[1] = item_reg[255:192];
            x_op[2] = item_reg[319:256];
            x_op[3] = item_reg[383:320];
            x_op[4] = item_reg[447:384];
        end
    end

    for (genvar k = 0; k < NL; k++) begin : g_lane
        mtc_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (lane_ctl),
            .x_op    (x_op[k]),
            .w_op    (w_reg),
            .inv_phi (inv_phi_reg),
            .sc_re   (sc_re[k]),
            .sc_im   (sc_im[k])
        );
    end

    // ---------------------------------------------------------------- merge
    assign sum_sq = 64'(sq_re_reg) + 64'(sq_im_reg);

    mtc_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .val     (sum_sq),
        .busy    (sqrt_busy),
        .root    (root)
    );

    for (genvar c = 0; c < NC; c++) begin : g_div
        assign div_num[c] = (state_reg == mtc_pkg::S_DIV1) ? mk_num(sc_im[c+1], root)
                                                           : mk_num(sc_re[c+1], root);
        mtc_div #(.NW(NW)) u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (div_start),
            .num     (div_num[c]),
            .den     (root),
            .busy    (div_busy[c]),
            .quot    (div_quot[c])
        );
    end

    // ---------------------------------------------------------------- phasor
    assign wr = w_reg[63:32];
    assign wi = w_reg[31:0];
    assign pr = item_reg[63:32];
    assign pi = item_reg[31:0];

    // ---------------------------------------------------------------- control
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        logic signed [35:0] nre, nim;
        state_next = state_reg;
        first_next = first_reg;
        w_next     = w_reg;
        lane_ctl   = '0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        s_tready   = 1'b0;
        nre = mtc_pkg::rnd30({pw_rr_reg[63], pw_rr_reg} - {pw_ii_reg[63], pw_ii_reg});
        nim = mtc_pkg::rnd30({pw_ri_reg[63], pw_ri_reg} + {pw_ir_reg[63], pw_ir_reg});
        unique case (state_reg)
            mtc_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = mtc_pkg::S_MUL;
                end
            end
            mtc_pkg::S_MUL: begin
                lane_ctl.mul_en = 1'b1;
                state_next      = mtc_pkg::S_ACC1;
            end
            mtc_pkg::S_ACC1: begin
                lane_ctl.mul_en = 1'b1;
                lane_ctl.conj   = 1'b1;
                lane_ctl.acc_en = 1'b1;
                if (!last_reg) begin
                    w_next = {mtc_pkg::sat32({{4{nre[35]}}, nre}),
                              mtc_pkg::sat32({{4{nim[35]}}, nim})};
                end
                state_next = mtc_pkg::S_ACC2;
            end
            mtc_pkg::S_ACC2: begin
                // order zero carries no minus terms
                lane_ctl.acc_en = !first_reg;
                first_next      = 1'b0;
                state_next      = last_reg ? mtc_pkg::S_SCALE : mtc_pkg::S_IDLE;
            end
            mtc_pkg::S_SCALE: begin
                lane_ctl.scale_en = 1'b1;
                state_next        = mtc_pkg::S_SQ;
            end
            mtc_pkg::S_SQ: begin
                state_next = mtc_pkg::S_ROOT;
            end
            mtc_pkg::S_ROOT: begin
                sqrt_start = 1'b1;
                state_next = mtc_pkg::S_ROOTW;
            end
            mtc_pkg::S_ROOTW: begin
                if (!sqrt_busy) begin
                    state_next = low_reg ? mtc_pkg::S_DONE : mtc_pkg::S_DIV0;
                end
            end
            mtc_pkg::S_DIV0: begin
                div_start  = 1'b1;
                state_next = mtc_pkg::S_DIVW0;
            end
            mtc_pkg::S_DIVW0: begin
                if (!(|div_busy)) begin
                    state_next = mtc_pkg::S_DIV1;
                end
            end
            mtc_pkg::S_DIV1: begin
                div_start  = 1'b1;
                state_next = mtc_pkg::S_DIVW1;
            end
            mtc_pkg::S_DIVW1: begin
                if (!(|div_busy)) begin
                    state_next = mtc_pkg::S_DONE;
                end
            end
            mtc_pkg::S_DONE: begin
                // hold until the output register frees, then reopen the bin
                if (out_free) begin
                    lane_ctl.clear = 1'b1;
                    first_next     = 1'b1;
                    w_next         = mtc_pkg::PHASOR_ONE;
                    state_next     = mtc_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = mtc_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mtc_pkg::S_IDLE;
            first_reg    <= 1'b1;
            w_reg        <= mtc_pkg::PHASOR_ONE;
            m_tvalid_reg <= 1'b0;
            inv_phi_reg  <= mtc_pkg::INV_PHI_RESET;
            thresh_reg   <= mtc_pkg::THRESH_RESET;
        end else begin
            state_reg <= state_next;
            first_reg <= first_next;
            w_reg     <= w_next;
            if (state_reg == mtc_pkg::S_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr) begin
                if (paddr[2] == mtc_pkg::REG_THRESH) begin
                    thresh_reg <= pwdata[30:0];
                end else begin
                    inv_phi_reg <= pwdata[15:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_tdata;
            last_reg <= s_tlast;
        end
        if (state_reg == mtc_pkg::S_MUL) begin
            pw_rr_reg <= wr * pr;
            pw_ii_reg <= wi * pi;
            pw_ri_reg <= wr * pi;
            pw_ir_reg <= wi * pr;
        end
        if (state_reg == mtc_pkg::S_SQ) begin
            sq_re_reg <= sc_re[0] * sc_re[0];
            sq_im_reg <= sc_im[0] * sc_im[0];
            tt_reg    <= thresh_reg * thresh_reg;
        end
        if (state_reg == mtc_pkg::S_ROOT) begin
            low_reg <= !(sum_sq > {2'b00, tt_reg});
        end
        for (int c = 0; c < NC; c++) begin
            if (state_reg == mtc_pkg::S_DIVW0 && !(|div_busy)) begin
                gam_re_reg[c] <= fix_q(div_quot[c], sc_re[c+1][31]);
            end
            if (state_reg == mtc_pkg::S_DIVW1 && !(|div_busy)) begin
                gam_im_reg[c] <= fix_q(div_quot[c], sc_im[c+1][31]);
            end
        end
        if (state_reg == mtc_pkg::S_DONE && out_free) begin
            m_tdata_reg[63:0] <= {sc_re[0], sc_im[0]};
            for (int c = 0; c < NC; c++) begin
                m_tdata_reg[64*(c+1) +: 64] <= low_reg ? 64'd0
                                                       : {gam_re_reg[c], gam_im_reg[c]};
            end
            m_tuser_reg <= low_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

`ifndef SYNTH
    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == mtc_pkg::S_DONE))
        else $error("result raised outside bin close");

    a_idle_units: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!sqrt_busy && !(|div_busy)))
        else $error("input open while root or divider busy");

    a_low_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[319:64] == '0))
        else $error("low normalization with nonzero components");
`endif

endmodule
